### design/sdec_pkg.sv
// Shared types and constants for the signed decimal text converter.
package sdec_pkg;

  localparam int CAP_W      = 7;
  localparam int CNT_W      = 5;
  localparam int CHAR_W     = 8;
  localparam int DAB_STEPS  = 8;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET    = 7'd12;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_NONE    = 8'd0;
  localparam logic [3:0]        CHAR_ZERO_HI = 4'h3;

  // Register index, taken from paddr[2].
  localparam logic REG_BUF_CAPACITY = 1'b0;

  typedef struct packed {
    logic             ovf;
    logic             neg;
    logic [CNT_W-1:0] count;
  } sdec_ctl_t;

endpackage

### design/signed_int_to_decimal_ascii.sv
// Top level: signed integer to decimal ASCII text, with capacity register.
//
// A word enters on start while busy is low, one per cycle at most. It goes
// through an input stage (sign and magnitude), ceil(VALUE_WIDTH/8) BCD
// stages of eight shift-add-3 steps each, and a digit-count stage, then the
// serializer sends one character per cycle on strobe: the '-' if negative,
// then the digits, the last one flagged with is_last and the character
// count. A word that does not fit buf_capacity with its terminator gives one
// overflow character instead. The serializer sets the rate: it holds a word
// until its last character is sent (1 to 11 characters at 32 bits, one on
// overflow), and busy rises while it is full and the count stage holds the next word.
// Results cannot be held off.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [VALUE_WIDTH-1:0]      value,
  output logic                               strobe,
  output logic [7:0]                         char_code,
  output logic                               is_last,
  output logic                               overflow,
  output logic [3:0]                         char_count,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sdec_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [sdec_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [sdec_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import sdec_pkg::*;

  localparam int NSTAGE = (VALUE_WIDTH + DAB_STEPS - 1) / DAB_STEPS;
  localparam int W_PAD  = NSTAGE * DAB_STEPS;
  localparam int NDIG   = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int IDX_W  = $clog2(NDIG);

  // configuration
  logic [CAP_W-1:0] buf_capacity;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel == REG_BUF_CAPACITY) begin
      buf_capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (reg_sel == REG_BUF_CAPACITY)
                  ? {{(APB_DATA_W-CAP_W){1'b0}}, buf_capacity} : '0;

  // pipeline control: the whole pipe moves when the count stage can hand off
  logic advance;
  logic emit_free;

  // input stage
  logic                   s0_valid;
  logic                   s0_neg;
  logic [W_PAD-1:0]       s0_mag;
  logic [VALUE_WIDTH-1:0] mag_next;

  assign mag_next = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_neg <= value[VALUE_WIDTH-1];
      s0_mag <= W_PAD'(mag_next);
    end
  end

  // BCD stages
  logic              dab_valid [NSTAGE+1];
  logic              dab_neg   [NSTAGE+1];
  logic [W_PAD-1:0]  dab_mag   [NSTAGE+1];
  logic [NDIG*4-1:0] dab_bcd   [NSTAGE+1];

  assign dab_valid[0] = s0_valid;
  assign dab_neg[0]   = s0_neg;
  assign dab_mag[0]   = s0_mag;
  assign dab_bcd[0]   = '0;

  for (genvar g = 0; g < NSTAGE; g++) begin : g_dab
    sdec_dabble #(
      .W_PAD (W_PAD),
      .NDIG  (NDIG)
    ) u_dab (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .in_valid  (dab_valid[g]),
      .in_neg    (dab_neg[g]),
      .in_mag    (dab_mag[g]),
      .in_bcd    (dab_bcd[g]),
      .out_valid (dab_valid[g+1]),
      .out_neg   (dab_neg[g+1]),
      .out_mag   (dab_mag[g+1]),
      .out_bcd   (dab_bcd[g+1])
    );
  end

  // count stage: highest nonzero digit, character count, capacity check
  logic              cs_valid;
  logic [NDIG*4-1:0] cs_digits;
  sdec_ctl_t         cs_ctl;
  logic [IDX_W-1:0]  hi_idx;
  logic [CNT_W-1:0]  count_next;
  sdec_ctl_t         ctl_next;
  logic [NDIG*4-1:0] last_bcd;

  assign last_bcd = dab_bcd[NSTAGE];

  always_comb begin
    hi_idx = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (last_bcd[d*4 +: 4] != 4'd0) begin
        hi_idx = IDX_W'(d);
      end
    end
  end

  assign count_next     = CNT_W'(hi_idx) + CNT_W'(1) + CNT_W'(dab_neg[NSTAGE]);
  assign ctl_next.count = count_next;
  assign ctl_next.neg   = dab_neg[NSTAGE];
  assign ctl_next.ovf   = CAP_W'(count_next) >= buf_capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      cs_valid <= 1'b0;
    end else if (advance) begin
      cs_valid <= dab_valid[NSTAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cs_digits <= last_bcd;
      cs_ctl    <= ctl_next;
    end
  end

  assign advance = !cs_valid || emit_free;
  assign busy    = !advance;

  sdec_emit #(
    .NDIG (NDIG)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (cs_valid),
    .digits     (cs_digits),
    .ctl        (cs_ctl),
    .free       (emit_free),
    .strobe     (strobe),
    .char_code  (char_code),
    .is_last    (is_last),
    .overflow   (overflow),
    .char_count (char_count)
  );

  // an item held at the count stage is not lost while the pipe is stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (cs_valid && !emit_free) |=> cs_valid)
    else $error("stalled word dropped");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cs_valid && strobe && !is_last))
    else $error("busy without a full serializer");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(cs_ctl))
    else $error("count stage changed during stall");

endmodule

### design/sdec_dabble.sv
// One pipeline stage of the binary to BCD conversion: eight shift-add-3 steps.
module sdec_dabble #(
  parameter int W_PAD = 32,
  parameter int NDIG  = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              in_valid,
  input  logic              in_neg,
  input  logic [W_PAD-1:0]  in_mag,
  input  logic [NDIG*4-1:0] in_bcd,
  output logic              out_valid,
  output logic              out_neg,
  output logic [W_PAD-1:0]  out_mag,
  output logic [NDIG*4-1:0] out_bcd
);
  import sdec_pkg::*;

  logic [W_PAD-1:0]  mag_next;
  logic [NDIG*4-1:0] bcd_next;

  always_comb begin
    mag_next = in_mag;
    bcd_next = in_bcd;
    for (int s = 0; s < DAB_STEPS; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_next[d*4 +: 4] >= 4'd5) begin
          bcd_next[d*4 +: 4] = bcd_next[d*4 +: 4] + 4'd3;
        end
      end
      bcd_next = {bcd_next[NDIG*4-2:0], mag_next[W_PAD-1]};
      mag_next = {mag_next[W_PAD-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_neg <= in_neg;
      out_mag <= mag_next;
      out_bcd <= bcd_next;
    end
  end

endmodule

### design/sdec_emit.sv
// Character serializer: sends the sign and digits of one word, or its overflow character, one per cycle.
module sdec_emit #(
  parameter int NDIG = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [NDIG*4-1:0]            digits,
  input  sdec_pkg::sdec_ctl_t          ctl,
  output logic                         free,
  output logic                         strobe,
  output logic [sdec_pkg::CHAR_W-1:0]  char_code,
  output logic                         is_last,
  output logic                         overflow,
  output logic [3:0]                   char_count
);
  import sdec_pkg::*;

  localparam int IDX_W = $clog2(NDIG);

  logic              active;
  logic              ovf;
  logic              sign_pend;
  logic [IDX_W-1:0]  idx;
  logic [NDIG*4-1:0] digits_q;
  logic [CNT_W-1:0]  count_q;
  logic              finishing;
  logic              take;
  logic [IDX_W-1:0]  start_idx;
  logic [3:0]        cur_digit;

  assign finishing = active && (ovf || (!sign_pend && idx == '0));
  assign free      = !active || finishing;
  assign take      = load && free;
  assign start_idx = IDX_W'(ctl.count - CNT_W'(1) - CNT_W'(ctl.neg));
  assign cur_digit = digits_q[idx*4 +: 4];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (take) begin
      active <= 1'b1;
    end else if (finishing) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ovf       <= ctl.ovf;
      sign_pend <= ctl.neg && !ctl.ovf;
      idx       <= start_idx;
      digits_q  <= digits;
      count_q   <= ctl.count;
    end else if (active && !finishing) begin
      if (sign_pend) begin
        sign_pend <= 1'b0;
      end else begin
        idx <= idx - 1'b1;
      end
    end
  end

  always_comb begin
    if (!active || ovf) begin
      char_code = CHAR_NONE;
    end else if (sign_pend) begin
      char_code = CHAR_MINUS;
    end else begin
      char_code = {CHAR_ZERO_HI, cur_digit};
    end
  end

  assign strobe     = active;
  assign is_last    = finishing;
  assign overflow   = active && ovf;
  assign char_count = (finishing && !ovf) ? count_q[3:0] : 4'd0;

  // a word keeps streaming until its last character
  a_word_runs: assert property (@(posedge clk) disable iff (rst)
    (strobe && !is_last) |=> strobe)
    else $error("word ended without a last character");

  // the sign is sent once, and a digit follows it
  a_sign_once: assert property (@(posedge clk) disable iff (rst)
    (strobe && char_code == CHAR_MINUS) |=> (strobe && char_code != CHAR_MINUS))
    else $error("sign not followed by a digit");

  a_ovf_single: assert property (@(posedge clk) disable iff (rst)
    (strobe && overflow) |-> (is_last && char_count == 4'd0 && char_code == CHAR_NONE))
    else $error("overflow word malformed");

  a_count_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && !is_last) |-> (char_count == 4'd0))
    else $error("count shown before last character");

endmodule

### dv/signed_int_to_decimal_ascii_tb.sv
// Testbench for signed_int_to_decimal_ascii: directed and random conversions checked per char.
module signed_int_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdec_pkg::*;

  localparam int VW = 32;
  localparam logic [CHAR_W-1:0] DIGIT_BASE = {CHAR_ZERO_HI, 4'h0};
  localparam logic [APB_ADDR_W-1:0] ADDR_BUF_CAPACITY = {REG_BUF_CAPACITY, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED     = {~REG_BUF_CAPACITY, 2'b00};
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 1000;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
    logic       overflow;
    logic [3:0] char_count;
  } char_word_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic signed [VW-1:0]   value;
  logic                   strobe;
  logic [7:0]             char_code;
  logic                   is_last;
  logic                   overflow;
  logic [3:0]             char_count;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  char_word_t       pending_chars[$];
  logic [CAP_W-1:0] model_cap;
  int               n_mismatch = 0;
  bit               bursty = 1'b0;

  signed_int_to_decimal_ascii #(.VALUE_WIDTH(VW)) i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .strobe     (strobe),
    .char_code  (char_code),
    .is_last    (is_last),
    .overflow   (overflow),
    .char_count (char_count),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #4 clk = ~clk;

  // Expected text of one word: sign, digits MSD first, or a lone overflow char.
  function automatic void predict_text(input logic signed [VW-1:0] v);
    logic             neg;
    logic [VW-1:0]    mag;
    logic [7:0]       rev[20];
    int               nd;
    int               cnt;
    char_word_t       w;
    neg = v[VW-1];
    mag = neg ? (~v + 1'b1) : v;
    nd  = 0;
    do begin
      rev[nd] = DIGIT_BASE + 8'(mag % 10);
      nd++;
      mag = mag / 10;
    end while (mag != 0);
    cnt = nd + (neg ? 1 : 0);
    if (cnt >= int'(model_cap)) begin
      w = '{char_code: CHAR_NONE, is_last: 1'b1, overflow: 1'b1, char_count: 4'd0};
      pending_chars.push_back(w);
      return;
    end
    if (neg) begin
      w = '{char_code: CHAR_MINUS, is_last: 1'b0, overflow: 1'b0, char_count: 4'd0};
      pending_chars.push_back(w);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      w.char_code  = rev[i];
      w.is_last    = (i == 0);
      w.overflow   = 1'b0;
      w.char_count = (i == 0) ? 4'(cnt) : 4'd0;
      pending_chars.push_back(w);
    end
  endfunction

  // Mix of full-range words, words of a chosen digit count, and extremes.
  function automatic logic signed [VW-1:0] random_value();
    int          kind;
    int          nd;
    longint      lo;
    longint      hi;
    logic [31:0] m;
    kind = $urandom_range(0, 9);
    if (kind < 3) return $urandom;
    if (kind == 3) begin
      case ($urandom_range(0, 4))
        0:       return 32'h0000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h8000_0000;
        3:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0001;
      endcase
    end
    nd = $urandom_range(1, 10);
    lo = 1;
    repeat (nd - 1) lo = lo * 10;
    hi = lo * 10 - 1;
    if (nd == 1) lo = 0;
    if (hi > 64'd2147483647) hi = 64'd2147483647;
    m = $urandom_range(int'(hi), int'(lo));
    if ($urandom_range(0, 1) == 1) m = -m;
    return m;
  endfunction

  // One word on start/busy; expectations are queued at the accepting edge.
  task automatic send_word(input logic signed [VW-1:0] v);
    int gap;
    gap = bursty ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    value <= v;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_text(v);
  endtask

  // Idle the input side and wait for every queued char, then let the pipe settle.
  task automatic drain();
    int waited;
    @(negedge clk);
    start <= 1'b0;
    waited = 0;
    while (pending_chars.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_chars.size() != 0) begin
      $display("%0t: %0d chars never arrived, next expected %h", $time,
               pending_chars.size(), pending_chars[0]);
      n_mismatch++;
      pending_chars.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    drain();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    if (addr == ADDR_BUF_CAPACITY) model_cap = data[CAP_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_capacity_readback();
    logic [APB_DATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_BUF_CAPACITY;
    @(negedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    got = prdata;
    if (got !== APB_DATA_W'(model_cap)) begin
      $display("%0t: buf_capacity readback expected %0d actual %h", $time, model_cap, got);
      n_mismatch++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_capacity(input logic [31:0] data);
    apb_write(ADDR_BUF_CAPACITY, data);
    check_capacity_readback();
  endtask

  // Every strobe must match the oldest expected char, field by field.
  always @(posedge clk) begin
    char_word_t want;
    if (!rst && strobe === 1'b1) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected char expected none actual code %0d last %b ovf %b cnt %0d",
                 $time, char_code, is_last, overflow, char_count);
        n_mismatch++;
      end else begin
        want = pending_chars.pop_front();
        if (char_code !== want.char_code || is_last !== want.is_last ||
            overflow !== want.overflow || char_count !== want.char_count) begin
          $display("%0t: char mismatch expected code %0d last %b ovf %b cnt %0d",
                   $time, want.char_code, want.is_last, want.overflow, want.char_count);
          $display("%0t:                 actual code %0d last %b ovf %b cnt %0d",
                   $time, char_code, is_last, overflow, char_count);
          n_mismatch++;
        end
      end
    end
  end

  task automatic test_reset_capacity();
    check_capacity_readback();
  endtask

  // Default capacity: zero, one digit, carries into new digit counts, extremes.
  task automatic test_directed_values();
    send_word(32'sd0);
    send_word(32'sd1);
    send_word(-32'sd1);
    send_word(32'sd9);
    send_word(-32'sd9);
    send_word(32'sd10);
    send_word(-32'sd10);
    send_word(32'sd99);
    send_word(32'sd100);
    send_word(32'sh7FFF_FFFF);
    send_word(32'sh8000_0000);
    send_word(32'sd1000000000);
    send_word(-32'sd1234567890);
  endtask

  // Overflow boundary: count equal to capacity overflows, one less fits.
  task automatic test_capacity_extremes();
    write_capacity(32'd11);
    send_word(32'sh8000_0000);
    send_word(32'sh7FFF_FFFF);
    write_capacity(32'd1);
    send_word(32'sd0);
    write_capacity(32'd2);
    send_word(32'sd0);
    send_word(-32'sd1);
    write_capacity(32'd0);
    send_word(32'sd0);
    send_word(32'sd5);
    write_capacity(32'd64);
    send_word(32'sh8000_0000);
    // upper data bits must be dropped, leaving 127
    write_capacity(32'hFFFF_FF7F);
    send_word(32'sh8000_0000);
  endtask

  // Write to an unmapped address must leave capacity alone.
  task automatic test_unmapped_write();
    write_capacity(32'd2);
    apb_write(ADDR_UNMAPPED, 32'd0);
    check_capacity_readback();
    send_word(32'sd7);
  endtask

  task automatic test_random_phases();
    logic [CAP_W-1:0] cap;
    for (int p = 0; p < 6; p++) begin
      case ($urandom_range(0, 5))
        0:       cap = 7'd0;
        1:       cap = 7'd64;
        2:       cap = 7'd127;
        3:       cap = $urandom_range(0, 127);
        default: cap = $urandom_range(1, 13);
      endcase
      write_capacity(($urandom & ~32'h7F) | 32'(cap));
      bursty = ($urandom_range(0, 2) == 0);
      repeat (30) send_word(random_value());
    end
    bursty = 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    value     = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    model_cap = CAP_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_capacity();
    test_directed_values();
    test_capacity_extremes();
    test_unmapped_write();
    test_random_phases();

    drain();
    if (n_mismatch == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
